// ===== rtl/rk4j2_pkg.sv =====
// Shared types and constants of the RK4 J2 orbit propagator.
package rk4j2_pkg;

    localparam int POS_W = 44;
    localparam int VEL_W = 40;
    localparam int STEP_W = 28;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OBL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VZ = 3'd6;

    localparam logic signed [63:0] POS_LIM = 64'sd6553600000000;
    localparam logic signed [63:0] VEL_LIM = 64'sd335544320000;
    localparam logic [63:0] ACC_MAX = 64'd1 << 47;
    localparam logic [63:0] INC_MAX = 64'd1 << 62;
    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MU_M = 64'd398600441800000;
    localparam logic [63:0] RE16SQ = 64'd102050192 * 64'd102050192;
    localparam logic [63:0] KJ = (64'd324789 << 40) / 64'd200000000;
    localparam logic [63:0] ONE32 = 64'd1 << 32;
    localparam logic [63:0] TWO40 = 64'd1 << 40;

    typedef struct packed {
        logic                    func;
        logic [STEP_W-1:0]       step_seconds;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] out_pos_x;
        logic signed [POS_W-1:0] out_pos_y;
        logic signed [POS_W-1:0] out_pos_z;
        logic signed [VEL_W-1:0] out_vel_x;
        logic signed [VEL_W-1:0] out_vel_y;
        logic signed [VEL_W-1:0] out_vel_z;
        logic                    overflow_flag;
    } res_t;

    typedef struct packed {
        logic        start;
        logic        mul_only;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] lim;
    } mdu_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] result;
    } mdu_rsp_t;

    typedef enum logic [2:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_CHK,
        MDU_DIV,
        MDU_FIN,
        MDU_DONE
    } mdu_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_SQRT,
        ST_R2,
        ST_G,
        ST_C,
        ST_Q,
        ST_S,
        ST_T1,
        ST_T2,
        ST_W,
        ST_CJ,
        ST_CLAMP,
        ST_ACCUM,
        ST_STP,
        ST_STV,
        ST_OUT
    } seq_state_t;

endpackage

// ===== rtl/rk4j2_muldiv.sv =====
// Shared multiply-divide unit: floor(a*b/d) saturated to a limit, or a plain product.
module rk4j2_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  rk4j2_pkg::mdu_req_t req,
    output rk4j2_pkg::mdu_rsp_t rsp
);

    rk4j2_pkg::mdu_state_t state_reg, state_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [63:0]  d_reg, d_next;
    logic [63:0]  lim_reg, lim_next;
    logic         mul_only_reg, mul_only_next;
    logic [127:0] prod_reg, prod_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  quo_reg, quo_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [63:0]  res_reg, res_next;
    logic         ovf_reg, ovf_next;

    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  rs;
    logic         take;
    logic         early;

    always_comb
    begin
        ah = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        bh = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = 64'(ah) * 64'(bh);
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        rs = {rem_reg[62:0], prod_reg[63]};
        take = rem_reg[63] | (rs >= d_reg);
        early = mul_only_reg | (d_reg == 64'd0) | (prod_reg[127:64] >= d_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rk4j2_pkg::MDU_IDLE:
            begin
                if (req.start)
                    state_next = rk4j2_pkg::MDU_MUL;
            end
            rk4j2_pkg::MDU_MUL:
            begin
                if (cnt_reg[1:0] == 2'd3)
                    state_next = rk4j2_pkg::MDU_CHK;
            end
            rk4j2_pkg::MDU_CHK:
            begin
                state_next = early ? rk4j2_pkg::MDU_DONE : rk4j2_pkg::MDU_DIV;
            end
            rk4j2_pkg::MDU_DIV:
            begin
                if (cnt_reg == 6'd63)
                    state_next = rk4j2_pkg::MDU_FIN;
            end
            rk4j2_pkg::MDU_FIN:  state_next = rk4j2_pkg::MDU_DONE;
            rk4j2_pkg::MDU_DONE: state_next = rk4j2_pkg::MDU_IDLE;
            default:             state_next = rk4j2_pkg::MDU_IDLE;
        endcase
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        d_next = d_reg;
        lim_next = lim_reg;
        mul_only_next = mul_only_reg;
        prod_next = prod_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        ovf_next = ovf_reg;
        case (state_reg)
            rk4j2_pkg::MDU_IDLE:
            begin
                if (req.start)
                begin
                    a_next = req.a;
                    b_next = req.b;
                    d_next = req.d;
                    lim_next = req.lim;
                    mul_only_next = req.mul_only;
                    prod_next = '0;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            rk4j2_pkg::MDU_MUL:
            begin
                prod_next = prod_reg + pp_sh;
                cnt_next = cnt_reg + 6'd1;
            end
            rk4j2_pkg::MDU_CHK:
            begin
                cnt_next = '0;
                quo_next = '0;
                rem_next = prod_reg[127:64];
                if (mul_only_reg)
                    res_next = prod_reg[63:0];
                else if (early)
                begin
                    res_next = lim_reg;
                    ovf_next = 1'b1;
                end
            end
            rk4j2_pkg::MDU_DIV:
            begin
                prod_next = {prod_reg[127:64], prod_reg[62:0], 1'b0};
                rem_next = take ? rs - d_reg : rs;
                quo_next = {quo_reg[62:0], take};
                cnt_next = cnt_reg + 6'd1;
            end
            rk4j2_pkg::MDU_FIN:
            begin
                if (quo_reg > lim_reg)
                begin
                    res_next = lim_reg;
                    ovf_next = 1'b1;
                end
                else
                    res_next = quo_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == rk4j2_pkg::MDU_DONE);
        rsp.ovf = ovf_reg;
        rsp.result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rk4j2_pkg::MDU_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        d_reg <= d_next;
        lim_reg <= lim_next;
        mul_only_reg <= mul_only_next;
        prod_reg <= prod_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        ovf_reg <= ovf_next;
    end

endmodule

// ===== rtl/rk4_j2_orbit_propagator.sv =====
// Top level of the RK4 orbit propagator with two-body and J2 gravity.
//
// A load transaction copies the start registers, saturated to the position and velocity
// limits, into the state. A propagate transaction runs four acceleration evaluations and
// four Runge-Kutta stages on one shared multiply-divide unit (four 32x32 partial products,
// then a 64-step restoring division, or the product alone) plus a 32-step integer square
// root. Oblateness adds further operations to each evaluation, and an operation that
// saturates early skips the division.
// The block takes no new transaction until the result is in the output register,
// and that register holds a result until it is taken.
module rk4_j2_orbit_propagator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  rk4j2_pkg::cmd_t                      cmd,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output rk4j2_pkg::res_t                      res,
    input  logic                                 cfg_we,
    input  logic [rk4j2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rk4j2_pkg::POS_W-1:0]          cfg_wdata
);

    function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
        if (v > lim)
            sat64 = lim;
        else if (v < -lim)
            sat64 = -lim;
        else
            sat64 = v;
    endfunction

    function automatic logic hit64(input logic signed [63:0] v,
                                   input logic signed [63:0] lim);
        hit64 = (v > lim) || (v < -lim);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        abs64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    rk4j2_pkg::seq_state_t state_reg, state_next;
    logic        wait_reg, wait_next;
    logic [1:0]  i_reg, i_next;
    logic [1:0]  k_reg, k_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic        obl_reg;
    logic [27:0] h_reg, h_next;

    logic signed [43:0] spos_reg [3];
    logic signed [39:0] svel_reg [3];
    logic signed [43:0] pos_reg [3];
    logic signed [43:0] pos_next [3];
    logic signed [39:0] vel_reg [3];
    logic signed [39:0] vel_next [3];
    logic signed [43:0] pt_reg [3];
    logic signed [43:0] pt_next [3];
    logic signed [39:0] vt_reg [3];
    logic signed [39:0] vt_next [3];
    logic signed [49:0] a_reg [3];
    logic signed [49:0] a_next [3];
    logic signed [51:0] sa_reg [3];
    logic signed [51:0] sa_next [3];
    logic signed [43:0] sv_reg [3];
    logic signed [43:0] sv_next [3];

    logic [63:0] sum_reg, sum_next;
    logic [63:0] zsq_reg, zsq_next;
    logic [63:0] sqn_reg, sqn_next;
    logic [63:0] sqres_reg, sqres_next;
    logic [63:0] sqbit_reg, sqbit_next;
    logic [31:0] r_reg, r_next;
    logic [63:0] r2_reg, r2_next;
    logic [47:0] g_reg, g_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] s_reg, s_next;
    logic [47:0] t_reg, t_next;
    logic [47:0] w_reg, w_next;
    logic        res_valid_reg, res_valid_next;
    rk4j2_pkg::res_t res_reg, res_next;

    rk4j2_pkg::mdu_req_t mreq;
    rk4j2_pkg::mdu_rsp_t mrsp;
    logic mdu_use;
    logic fire;

    logic signed [44:0] pt_ext;
    logic [44:0]        pt_mag;
    logic [31:0]        m_cur;
    logic               neg_cur;
    logic signed [63:0] f_cur;
    logic               f_neg;
    logic [63:0]        f_mag;
    logic [63:0]        sq_try;
    logic               sq_ge;
    logic [63:0]        sqres_step;
    logic [63:0]        sqn_step;
    logic signed [63:0] stg_x;
    logic [63:0]        stg_d;
    logic signed [63:0] stg_base;
    logic signed [63:0] stg_sum;
    logic signed [49:0] c_acc;
    logic signed [63:0] tmp64;

    rk4j2_muldiv u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign fire = wait_reg & mrsp.done;
    assign cmd_ready = (state_reg == rk4j2_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    // Operand shaping for the current component.
    always_comb
    begin
        pt_ext = {pt_reg[i_reg][43], pt_reg[i_reg]};
        pt_mag = pt_ext[44] ? 45'(-pt_ext) : 45'(pt_ext);
        m_cur = pt_mag[43:12];
        neg_cur = pt_reg[i_reg][43];
        f_cur = $signed(64'(s_reg * 64'd5)) -
                $signed((i_reg == 2'd2) ? (rk4j2_pkg::ONE32 * 64'd3) : rk4j2_pkg::ONE32);
        f_neg = f_cur[63];
        f_mag = abs64(f_cur);
        sq_try = sqres_reg + sqbit_reg;
        sq_ge = (sqn_reg >= sq_try);
        sqres_step = sq_ge ? (sqres_reg >> 1) + sqbit_reg : sqres_reg >> 1;
        sqn_step = sq_ge ? sqn_reg - sq_try : sqn_reg;
        if (state_reg == rk4j2_pkg::ST_STP)
            stg_x = (k_reg == 2'd3) ? {{20{sv_reg[i_reg][43]}}, sv_reg[i_reg]}
                                    : {{24{vt_reg[i_reg][39]}}, vt_reg[i_reg]};
        else
            stg_x = (k_reg == 2'd3) ? {{12{sa_reg[i_reg][51]}}, sa_reg[i_reg]}
                                    : {{14{a_reg[i_reg][49]}}, a_reg[i_reg]};
        case (k_reg)
            2'd2:    stg_d = 64'd1 << 24;
            2'd3:    stg_d = 64'd6 << 24;
            default: stg_d = 64'd1 << 25;
        endcase
        if (state_reg == rk4j2_pkg::ST_STP)
            stg_base = {{20{pos_reg[i_reg][43]}}, pos_reg[i_reg]};
        else
            stg_base = {{24{vel_reg[i_reg][39]}}, vel_reg[i_reg]};
        stg_sum = stg_x[63] ? stg_base - $signed(mrsp.result)
                            : stg_base + $signed(mrsp.result);
        c_acc = $signed({2'b00, mrsp.result[47:0]});
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rk4j2_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = cmd.func ? rk4j2_pkg::ST_SQ : rk4j2_pkg::ST_LOAD;
            end
            rk4j2_pkg::ST_LOAD: state_next = rk4j2_pkg::ST_OUT;
            rk4j2_pkg::ST_SQ:
            begin
                if (fire && i_reg == 2'd2)
                    state_next = rk4j2_pkg::ST_SQRT;
            end
            rk4j2_pkg::ST_SQRT:
            begin
                if (cnt_reg == 5'd31)
                    state_next = (sqres_step == 64'd0) ? rk4j2_pkg::ST_CLAMP
                                                       : rk4j2_pkg::ST_R2;
            end
            rk4j2_pkg::ST_R2: if (fire) state_next = rk4j2_pkg::ST_G;
            rk4j2_pkg::ST_G:  if (fire) state_next = rk4j2_pkg::ST_C;
            rk4j2_pkg::ST_C:
            begin
                if (fire && i_reg == 2'd2)
                    state_next = obl_reg ? rk4j2_pkg::ST_Q : rk4j2_pkg::ST_CLAMP;
            end
            rk4j2_pkg::ST_Q:  if (fire) state_next = rk4j2_pkg::ST_S;
            rk4j2_pkg::ST_S:  if (fire) state_next = rk4j2_pkg::ST_T1;
            rk4j2_pkg::ST_T1: if (fire) state_next = rk4j2_pkg::ST_T2;
            rk4j2_pkg::ST_T2: if (fire) state_next = rk4j2_pkg::ST_W;
            rk4j2_pkg::ST_W:  if (fire) state_next = rk4j2_pkg::ST_CJ;
            rk4j2_pkg::ST_CJ:
            begin
                if (fire)
                    state_next = (i_reg == 2'd2) ? rk4j2_pkg::ST_CLAMP : rk4j2_pkg::ST_W;
            end
            rk4j2_pkg::ST_CLAMP: state_next = rk4j2_pkg::ST_ACCUM;
            rk4j2_pkg::ST_ACCUM: state_next = rk4j2_pkg::ST_STP;
            rk4j2_pkg::ST_STP:
            begin
                if (fire && i_reg == 2'd2)
                    state_next = rk4j2_pkg::ST_STV;
            end
            rk4j2_pkg::ST_STV:
            begin
                if (fire && i_reg == 2'd2)
                    state_next = (k_reg == 2'd3) ? rk4j2_pkg::ST_OUT : rk4j2_pkg::ST_SQ;
            end
            rk4j2_pkg::ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                    state_next = rk4j2_pkg::ST_IDLE;
            end
            default: state_next = rk4j2_pkg::ST_IDLE;
        endcase
    end

    // Datapath and unit requests.
    always_comb
    begin
        wait_next = wait_reg;
        i_next = i_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        h_next = h_reg;
        pos_next = pos_reg;
        vel_next = vel_reg;
        pt_next = pt_reg;
        vt_next = vt_reg;
        a_next = a_reg;
        sa_next = sa_reg;
        sv_next = sv_reg;
        sum_next = sum_reg;
        zsq_next = zsq_reg;
        sqn_next = sqn_reg;
        sqres_next = sqres_reg;
        sqbit_next = sqbit_reg;
        r_next = r_reg;
        r2_next = r2_reg;
        g_next = g_reg;
        q_next = q_reg;
        s_next = s_reg;
        t_next = t_reg;
        w_next = w_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        mreq = '0;
        mdu_use = 1'b0;
        tmp64 = '0;
        case (state_reg)
            rk4j2_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    h_next = cmd.step_seconds;
                    ovf_next = 1'b0;
                    k_next = 2'd0;
                    i_next = 2'd0;
                    wait_next = 1'b0;
                    for (int j = 0; j < 3; j++)
                    begin
                        pt_next[j] = pos_reg[j];
                        vt_next[j] = vel_reg[j];
                        sv_next[j] = '0;
                        sa_next[j] = '0;
                    end
                end
            end
            rk4j2_pkg::ST_LOAD:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    tmp64 = {{20{spos_reg[j][43]}}, spos_reg[j]};
                    pos_next[j] = 44'(sat64(tmp64, rk4j2_pkg::POS_LIM));
                    ovf_next = ovf_next | hit64(tmp64, rk4j2_pkg::POS_LIM);
                    tmp64 = {{24{svel_reg[j][39]}}, svel_reg[j]};
                    vel_next[j] = 40'(sat64(tmp64, rk4j2_pkg::VEL_LIM));
                    ovf_next = ovf_next | hit64(tmp64, rk4j2_pkg::VEL_LIM);
                end
            end
            rk4j2_pkg::ST_SQ:
            begin
                mdu_use = 1'b1;
                mreq.mul_only = 1'b1;
                mreq.a = {32'd0, m_cur};
                mreq.b = {32'd0, m_cur};
                if (fire)
                begin
                    sum_next = ((i_reg == 2'd0) ? 64'd0 : sum_reg) + mrsp.result;
                    i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                    if (i_reg == 2'd2)
                    begin
                        zsq_next = mrsp.result;
                        sqn_next = sum_next;
                        sqres_next = '0;
                        sqbit_next = 64'd1 << 62;
                        cnt_next = '0;
                    end
                end
            end
            rk4j2_pkg::ST_SQRT:
            begin
                sqn_next = sqn_step;
                sqres_next = sqres_step;
                sqbit_next = sqbit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    r_next = sqres_step[31:0];
                    // A zero radius gives no acceleration and flags the item.
                    if (sqres_step == 64'd0)
                    begin
                        ovf_next = 1'b1;
                        for (int j = 0; j < 3; j++)
                            a_next[j] = '0;
                    end
                end
            end
            rk4j2_pkg::ST_R2:
            begin
                mdu_use = 1'b1;
                mreq.mul_only = 1'b1;
                mreq.a = {32'd0, r_reg};
                mreq.b = {32'd0, r_reg};
                if (fire)
                    r2_next = mrsp.result;
            end
            rk4j2_pkg::ST_G:
            begin
                mdu_use = 1'b1;
                mreq.a = rk4j2_pkg::MU_M;
                mreq.b = rk4j2_pkg::TWO40;
                mreq.d = r2_reg;
                mreq.lim = rk4j2_pkg::ACC_MAX;
                if (fire)
                    g_next = mrsp.result[47:0];
            end
            rk4j2_pkg::ST_C:
            begin
                mdu_use = 1'b1;
                mreq.a = {16'd0, g_reg};
                mreq.b = {32'd0, m_cur};
                mreq.d = {32'd0, r_reg};
                mreq.lim = rk4j2_pkg::ACC_MAX;
                if (fire)
                begin
                    a_next[i_reg] = neg_cur ? c_acc : -c_acc;
                    i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                end
            end
            rk4j2_pkg::ST_Q:
            begin
                mdu_use = 1'b1;
                mreq.a = rk4j2_pkg::RE16SQ;
                mreq.b = rk4j2_pkg::ONE32;
                mreq.d = r2_reg;
                mreq.lim = rk4j2_pkg::Q_MAX;
                if (fire)
                    q_next = mrsp.result;
            end
            rk4j2_pkg::ST_S:
            begin
                mdu_use = 1'b1;
                mreq.a = zsq_reg;
                mreq.b = rk4j2_pkg::ONE32;
                mreq.d = r2_reg;
                mreq.lim = rk4j2_pkg::Q_MAX;
                if (fire)
                    s_next = mrsp.result;
            end
            rk4j2_pkg::ST_T1:
            begin
                mdu_use = 1'b1;
                mreq.a = {16'd0, g_reg};
                mreq.b = q_reg;
                mreq.d = rk4j2_pkg::ONE32;
                mreq.lim = rk4j2_pkg::ACC_MAX;
                if (fire)
                    t_next = mrsp.result[47:0];
            end
            rk4j2_pkg::ST_T2:
            begin
                mdu_use = 1'b1;
                mreq.a = {16'd0, t_reg};
                mreq.b = rk4j2_pkg::KJ;
                mreq.d = rk4j2_pkg::TWO40;
                mreq.lim = rk4j2_pkg::ACC_MAX;
                if (fire)
                    t_next = mrsp.result[47:0];
            end
            rk4j2_pkg::ST_W:
            begin
                mdu_use = 1'b1;
                mreq.a = {16'd0, t_reg};
                mreq.b = f_mag;
                mreq.d = rk4j2_pkg::ONE32;
                mreq.lim = rk4j2_pkg::ACC_MAX;
                if (fire)
                    w_next = mrsp.result[47:0];
            end
            rk4j2_pkg::ST_CJ:
            begin
                mdu_use = 1'b1;
                mreq.a = {16'd0, w_reg};
                mreq.b = {32'd0, m_cur};
                mreq.d = {32'd0, r_reg};
                mreq.lim = rk4j2_pkg::ACC_MAX;
                if (fire)
                begin
                    a_next[i_reg] = a_reg[i_reg] + ((f_neg == neg_cur) ? c_acc : -c_acc);
                    i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                end
            end
            rk4j2_pkg::ST_CLAMP:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    tmp64 = {{14{a_reg[j][49]}}, a_reg[j]};
                    a_next[j] = 50'(sat64(tmp64, $signed(rk4j2_pkg::ACC_MAX)));
                    ovf_next = ovf_next | hit64(tmp64, $signed(rk4j2_pkg::ACC_MAX));
                end
            end
            rk4j2_pkg::ST_ACCUM:
            begin
                // The middle two stages carry weight two in the final sums.
                for (int j = 0; j < 3; j++)
                begin
                    if (k_reg == 2'd0 || k_reg == 2'd3)
                    begin
                        sa_next[j] = sa_reg[j] + {{2{a_reg[j][49]}}, a_reg[j]};
                        sv_next[j] = sv_reg[j] + {{4{vt_reg[j][39]}}, vt_reg[j]};
                    end
                    else
                    begin
                        sa_next[j] = sa_reg[j] + {a_reg[j][49], a_reg[j], 1'b0};
                        sv_next[j] = sv_reg[j] + {{3{vt_reg[j][39]}}, vt_reg[j], 1'b0};
                    end
                end
            end
            rk4j2_pkg::ST_STP:
            begin
                mdu_use = 1'b1;
                mreq.a = abs64(stg_x);
                mreq.b = {36'd0, h_reg};
                mreq.d = stg_d;
                mreq.lim = rk4j2_pkg::INC_MAX;
                if (fire)
                begin
                    ovf_next = ovf_reg | hit64(stg_sum, rk4j2_pkg::POS_LIM);
                    if (k_reg == 2'd3)
                        pos_next[i_reg] = 44'(sat64(stg_sum, rk4j2_pkg::POS_LIM));
                    else
                        pt_next[i_reg] = 44'(sat64(stg_sum, rk4j2_pkg::POS_LIM));
                    i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                end
            end
            rk4j2_pkg::ST_STV:
            begin
                mdu_use = 1'b1;
                mreq.a = abs64(stg_x);
                mreq.b = {36'd0, h_reg};
                mreq.d = stg_d;
                mreq.lim = rk4j2_pkg::INC_MAX;
                if (fire)
                begin
                    ovf_next = ovf_reg | hit64(stg_sum, rk4j2_pkg::VEL_LIM);
                    if (k_reg == 2'd3)
                        vel_next[i_reg] = 40'(sat64(stg_sum, rk4j2_pkg::VEL_LIM));
                    else
                        vt_next[i_reg] = 40'(sat64(stg_sum, rk4j2_pkg::VEL_LIM));
                    i_next = (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                    if (i_reg == 2'd2 && k_reg != 2'd3)
                        k_next = k_reg + 2'd1;
                end
            end
            rk4j2_pkg::ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next.out_pos_x = pos_reg[0];
                    res_next.out_pos_y = pos_reg[1];
                    res_next.out_pos_z = pos_reg[2];
                    res_next.out_vel_x = vel_reg[0];
                    res_next.out_vel_y = vel_reg[1];
                    res_next.out_vel_z = vel_reg[2];
                    res_next.overflow_flag = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
        // One operation at a time: issue once, then wait for its completion.
        if (mdu_use)
        begin
            mreq.start = ~wait_reg;
            wait_next = wait_reg ? ~mrsp.done : 1'b1;
            // A saturated quotient inside the unit also flags the item.
            if (fire)
                ovf_next = ovf_next | mrsp.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rk4j2_pkg::ST_IDLE;
            wait_reg <= 1'b0;
            i_reg <= '0;
            k_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            obl_reg <= 1'b1;
            res_valid_reg <= 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                spos_reg[j] <= '0;
                svel_reg[j] <= '0;
                pos_reg[j] <= '0;
                vel_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
            i_reg <= i_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            res_valid_reg <= res_valid_next;
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rk4j2_pkg::CFG_OBL: obl_reg <= cfg_wdata[0];
                    rk4j2_pkg::CFG_PX:  spos_reg[0] <= cfg_wdata;
                    rk4j2_pkg::CFG_PY:  spos_reg[1] <= cfg_wdata;
                    rk4j2_pkg::CFG_PZ:  spos_reg[2] <= cfg_wdata;
                    rk4j2_pkg::CFG_VX:  svel_reg[0] <= cfg_wdata[39:0];
                    rk4j2_pkg::CFG_VY:  svel_reg[1] <= cfg_wdata[39:0];
                    rk4j2_pkg::CFG_VZ:  svel_reg[2] <= cfg_wdata[39:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        pt_reg <= pt_next;
        vt_reg <= vt_next;
        a_reg <= a_next;
        sa_reg <= sa_next;
        sv_reg <= sv_next;
        sum_reg <= sum_next;
        zsq_reg <= zsq_next;
        sqn_reg <= sqn_next;
        sqres_reg <= sqres_next;
        sqbit_reg <= sqbit_next;
        r_reg <= r_next;
        r2_reg <= r2_next;
        g_reg <= g_next;
        q_reg <= q_next;
        s_reg <= s_next;
        t_reg <= t_next;
        w_reg <= w_next;
        res_reg <= res_next;
    end

endmodule

// ===== tb/tb_rk4_j2_orbit_propagator.sv =====
// Self-checking testbench for the RK4 J2 orbit propagator with a bit-exact state predictor.
`timescale 1ns / 1ps

module tb_rk4_j2_orbit_propagator;

    typedef longint vec3_t [3];

    localparam logic [rk4j2_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PROP = 1'b1;
    localparam longint LEO_POS = 64'sd460000000000;
    localparam longint LEO_VEL = 64'sd134000000000;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    rk4j2_pkg::cmd_t cmd;
    logic res_valid;
    logic res_ready;
    rk4j2_pkg::res_t res;
    logic cfg_we;
    logic [rk4j2_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rk4j2_pkg::POS_W-1:0] cfg_wdata;

    rk4j2_pkg::cmd_t pending_cmds[$];
    rk4j2_pkg::res_t expected_states[$];
    int mismatches;
    int results_seen;
    int hold_cycles;
    bit hold_done;
    bit no_idle;

    // Predictor copy of the block's registers and state.
    bit j2_on;
    longint load_pos[3];
    longint load_vel[3];
    longint orb_pos[3];
    longint orb_vel[3];
    bit step_ovf;

    rk4_j2_orbit_propagator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim)
        begin
            step_ovf = 1'b1;
            return lim;
        end
        if (v < -lim)
        begin
            step_ovf = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    // floor(a*b/d) on a full 128-bit product, saturated to mx.
    function automatic bit [63:0] scale_div(bit [63:0] a, bit [63:0] b, bit [63:0] d,
                                            bit [63:0] mx);
        bit [127:0] prod;
        bit [127:0] quo;
        prod = {64'd0, a} * {64'd0, b};
        if (d == 0 || prod[127:64] >= d)
        begin
            step_ovf = 1'b1;
            return mx;
        end
        quo = prod / {64'd0, d};
        if (quo[63:0] > mx)
        begin
            step_ovf = 1'b1;
            return mx;
        end
        return quo[63:0];
    endfunction

    function automatic longint signed_scale(longint a, bit [63:0] b, bit [63:0] d);
        longint m;
        m = longint'(scale_div(magn(a), b, d, rk4j2_pkg::INC_MAX));
        return a < 0 ? -m : m;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] root;
        bit [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic gravity_accel(input vec3_t p, output vec3_t acc);
        bit [63:0] m[3];
        bit neg[3];
        bit [63:0] sum;
        bit [63:0] r;
        bit [63:0] r2;
        bit [63:0] g;
        bit [63:0] c;
        bit [63:0] q;
        bit [63:0] s;
        bit [63:0] t;
        bit [63:0] w;
        longint f;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = p[i] < 0;
            m[i] = magn(p[i]) >> 12;
            sum = sum + m[i] * m[i];
        end
        r = int_sqrt(sum);
        if (r == 0)
        begin
            step_ovf = 1'b1;
            acc[0] = 0;
            acc[1] = 0;
            acc[2] = 0;
            return;
        end
        r2 = r * r;
        g = scale_div(rk4j2_pkg::MU_M, rk4j2_pkg::TWO40, r2, rk4j2_pkg::ACC_MAX);
        for (int i = 0; i < 3; i++)
        begin
            c = scale_div(g, m[i], r, rk4j2_pkg::ACC_MAX);
            acc[i] = neg[i] ? longint'(c) : -longint'(c);
        end
        if (j2_on)
        begin
            q = scale_div(rk4j2_pkg::RE16SQ, rk4j2_pkg::ONE32, r2, rk4j2_pkg::Q_MAX);
            s = scale_div(m[2] * m[2], rk4j2_pkg::ONE32, r2, rk4j2_pkg::Q_MAX);
            t = scale_div(g, q, rk4j2_pkg::ONE32, rk4j2_pkg::ACC_MAX);
            t = scale_div(t, rk4j2_pkg::KJ, rk4j2_pkg::TWO40, rk4j2_pkg::ACC_MAX);
            for (int i = 0; i < 3; i++)
            begin
                f = 5 * longint'(s) -
                    longint'(i == 2 ? 3 * rk4j2_pkg::ONE32 : rk4j2_pkg::ONE32);
                w = scale_div(t, magn(f), rk4j2_pkg::ONE32, rk4j2_pkg::ACC_MAX);
                c = scale_div(w, m[i], r, rk4j2_pkg::ACC_MAX);
                acc[i] = acc[i] + (((f < 0) == neg[i]) ? longint'(c) : -longint'(c));
            end
        end
        for (int i = 0; i < 3; i++)
            acc[i] = sat(acc[i], longint'(rk4j2_pkg::ACC_MAX));
    endtask

    // Stage state: the step's starting state plus slope * h / d.
    task automatic rk_stage(input vec3_t sv, input vec3_t sa, input bit [63:0] h,
                            input bit [63:0] d, output vec3_t p, output vec3_t v);
        for (int i = 0; i < 3; i++)
        begin
            p[i] = sat(orb_pos[i] + signed_scale(sv[i], h, d), rk4j2_pkg::POS_LIM);
            v[i] = sat(orb_vel[i] + signed_scale(sa[i], h, d), rk4j2_pkg::VEL_LIM);
        end
    endtask

    task automatic propagate_step(input bit [63:0] h);
        vec3_t p0, v0, a1, p2, v2, a2, p3, v3, a3, p4, v4, a4, sv, sa, pn, vn;
        p0 = orb_pos;
        v0 = orb_vel;
        gravity_accel(p0, a1);
        rk_stage(v0, a1, h, 64'd1 << 25, p2, v2);
        gravity_accel(p2, a2);
        rk_stage(v2, a2, h, 64'd1 << 25, p3, v3);
        gravity_accel(p3, a3);
        rk_stage(v3, a3, h, 64'd1 << 24, p4, v4);
        gravity_accel(p4, a4);
        for (int i = 0; i < 3; i++)
        begin
            sv[i] = v0[i] + 2 * v2[i] + 2 * v3[i] + v4[i];
            sa[i] = a1[i] + 2 * a2[i] + 2 * a3[i] + a4[i];
        end
        rk_stage(sv, sa, h, 64'd6 << 24, pn, vn);
        orb_pos = pn;
        orb_vel = vn;
    endtask

    task automatic predict_state(input rk4j2_pkg::cmd_t c);
        rk4j2_pkg::res_t e;
        step_ovf = 1'b0;
        if (c.func == FUNC_PROP)
            propagate_step(64'(c.step_seconds));
        else
            for (int i = 0; i < 3; i++)
            begin
                orb_pos[i] = sat(load_pos[i], rk4j2_pkg::POS_LIM);
                orb_vel[i] = sat(load_vel[i], rk4j2_pkg::VEL_LIM);
            end
        e.out_pos_x = orb_pos[0][rk4j2_pkg::POS_W-1:0];
        e.out_pos_y = orb_pos[1][rk4j2_pkg::POS_W-1:0];
        e.out_pos_z = orb_pos[2][rk4j2_pkg::POS_W-1:0];
        e.out_vel_x = orb_vel[0][rk4j2_pkg::VEL_W-1:0];
        e.out_vel_y = orb_vel[1][rk4j2_pkg::VEL_W-1:0];
        e.out_vel_z = orb_vel[2][rk4j2_pkg::VEL_W-1:0];
        e.overflow_flag = step_ovf;
        expected_states.push_back(e);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Driver: a new command is presented only when the previous one was taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                predict_state(cmd);
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 7))
                begin
                    cmd <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: one long hold-off after the hundredth result fills the block up.
    always @(posedge clk or negedge rst_n)
    begin
        rk4j2_pkg::res_t e;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (expected_states.size() == 0)
                begin
                    $error("result transaction with no expected state pending");
                    mismatches++;
                end
                else
                begin
                    e = expected_states.pop_front();
                    check_field("out_pos_x", e.out_pos_x, res.out_pos_x);
                    check_field("out_pos_y", e.out_pos_y, res.out_pos_y);
                    check_field("out_pos_z", e.out_pos_z, res.out_pos_z);
                    check_field("out_vel_x", e.out_vel_x, res.out_vel_x);
                    check_field("out_vel_y", e.out_vel_y, res.out_vel_y);
                    check_field("out_vel_z", e.out_vel_z, res.out_vel_z);
                    check_field("overflow_flag", e.overflow_flag, res.overflow_flag);
                end
                if (results_seen == 100 && !hold_done)
                begin
                    hold_cycles = 30000;
                    hold_done = 1'b1;
                end
            end
            if (hold_cycles > 0)
                hold_cycles--;
            res_ready <= (hold_cycles == 0) && (no_idle || $urandom_range(99) >= 7);
        end
    end

    task automatic write_reg(input logic [rk4j2_pkg::CFG_IDX_W-1:0] idx, input longint value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[rk4j2_pkg::POS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rk4j2_pkg::CFG_OBL)
            j2_on = value[0];
        else if (idx >= rk4j2_pkg::CFG_PX && idx <= rk4j2_pkg::CFG_PZ)
            load_pos[idx - rk4j2_pkg::CFG_PX] =
                longint'(signed'(value[rk4j2_pkg::POS_W-1:0]));
        else if (idx >= rk4j2_pkg::CFG_VX && idx <= rk4j2_pkg::CFG_VZ)
            load_vel[idx - rk4j2_pkg::CFG_VX] =
                longint'(signed'(value[rk4j2_pkg::VEL_W-1:0]));
    endtask

    task automatic write_state(input longint px, py, pz, vx, vy, vz);
        write_reg(rk4j2_pkg::CFG_PX, px);
        write_reg(rk4j2_pkg::CFG_PY, py);
        write_reg(rk4j2_pkg::CFG_PZ, pz);
        write_reg(rk4j2_pkg::CFG_VX, vx);
        write_reg(rk4j2_pkg::CFG_VY, vy);
        write_reg(rk4j2_pkg::CFG_VZ, vz);
    endtask

    task automatic queue_cmd(input logic f, input logic [rk4j2_pkg::STEP_W-1:0] h);
        rk4j2_pkg::cmd_t c;
        c.func = f;
        c.step_seconds = h;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() > 0 || cmd_valid || expected_states.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic longint rand_in(longint lim);
        bit [63:0] raw;
        raw = {$urandom, $urandom};
        return longint'(raw % 64'(2 * lim + 1)) - lim;
    endfunction

    function automatic logic [rk4j2_pkg::STEP_W-1:0] rand_step();
        logic [31:0] raw;
        if ($urandom_range(99) < 5)
            raw = $urandom;
        else
            raw = $urandom_range(60 * 65536);
        return raw[rk4j2_pkg::STEP_W-1:0];
    endfunction

    initial
    begin
        int kind;
        int n;
        mismatches = 0;
        results_seen = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        no_idle = 1'b0;
        j2_on = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            load_pos[i] = 0;
            load_vel[i] = 0;
            orb_pos[i] = 0;
            orb_vel[i] = 0;
        end
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the radius is zero; then the zero start state.
        queue_cmd(FUNC_PROP, 28'd65536);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'hFFF_FFFF);
        wait_idle();

        // A low orbit with and without oblateness, zero step and a one-hour step.
        write_reg(rk4j2_pkg::CFG_OBL, 1);
        write_state(LEO_POS, 0, 0, 0, LEO_VEL / 2, LEO_VEL / 2);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'd0);
        queue_cmd(FUNC_PROP, 28'd655360);
        queue_cmd(FUNC_PROP, 28'd235929600);
        wait_idle();
        write_reg(rk4j2_pkg::CFG_OBL, 0);
        write_reg(CFG_UNUSED, -1);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'd655360);
        wait_idle();

        // Over the pole, where the z term of J2 dominates.
        write_reg(rk4j2_pkg::CFG_OBL, 1);
        write_state(0, 0, LEO_POS, LEO_VEL, 0, 0);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'd3932160);
        wait_idle();

        // Limits of the ranges, then raw register values beyond them.
        write_state(rk4j2_pkg::POS_LIM, -rk4j2_pkg::POS_LIM, rk4j2_pkg::POS_LIM,
                    -rk4j2_pkg::VEL_LIM, rk4j2_pkg::VEL_LIM, -rk4j2_pkg::VEL_LIM);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'hFFF_FFFF);
        queue_cmd(FUNC_PROP, 28'd1);
        wait_idle();
        write_state(64'h7FF_FFFF_FFFF, 64'h800_0000_0000, 64'h555_5555_5555,
                    64'h7F_FFFF_FFFF, 64'h80_0000_0000, 64'hAA_AAAA_AAAA);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'h555_5555);
        wait_idle();

        // Near the center every component rounds away to zero.
        write_state(4095, -4095, 100, 1000, -1000, 0);
        queue_cmd(FUNC_LOAD, 28'd0);
        queue_cmd(FUNC_PROP, 28'hAAA_AAAA);
        wait_idle();

        for (int phase = 0; phase < 36; phase++)
        begin
            no_idle = (phase >= 8 && phase < 14);
            kind = $urandom_range(99);
            write_reg(rk4j2_pkg::CFG_OBL, $urandom_range(1));
            if (kind < 80)
                write_state(rand_in(LEO_POS), rand_in(LEO_POS), rand_in(LEO_POS),
                            rand_in(LEO_VEL), rand_in(LEO_VEL), rand_in(LEO_VEL));
            else if (kind < 92)
                write_state(rand_in(rk4j2_pkg::POS_LIM), rand_in(rk4j2_pkg::POS_LIM),
                            rand_in(rk4j2_pkg::POS_LIM), rand_in(rk4j2_pkg::VEL_LIM),
                            rand_in(rk4j2_pkg::VEL_LIM), rand_in(rk4j2_pkg::VEL_LIM));
            else
                write_state({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
            if ($urandom_range(3) == 0)
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            queue_cmd(FUNC_LOAD, rand_step());
            n = $urandom_range(30, 50);
            for (int k = 0; k < n; k++)
                queue_cmd($urandom_range(99) < 4 ? FUNC_LOAD : FUNC_PROP, rand_step());
            wait_idle();
        end
        no_idle = 1'b0;
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_states.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #600000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rk4j2_pkg.sv
rtl/rk4j2_muldiv.sv
rtl/rk4_j2_orbit_propagator.sv
tb/tb_rk4_j2_orbit_propagator.sv
